// ----- hw/rtl/fkp_pkg.sv -----
// ----------------------------------------------------------------------------
// fkp_pkg
// Shared constants for the arm position pipeline: default widths, fixed-point
// formats, register indexes and stage counts.
// ----------------------------------------------------------------------------
`default_nettype none

package fkp_pkg;

  localparam int unsigned ANGLE_BITS_DEF     = 16;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 16;

  localparam int unsigned LEN_W  = 16;
  localparam int unsigned POS_W  = 19;
  localparam int unsigned REACH_FRAC = 12;
  localparam int unsigned REACH_W    = 31;

  // pi/2 in Q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [63:0] Q30_HALF    = 64'd1 << 29;
  localparam logic [30:0] Q30_ONE     = 31'd1 << 30;

  localparam int unsigned HORNER_STEPS = 7;
  localparam int unsigned HORNER_LAT   = 3;
  localparam int unsigned SIN_LAT      = 2 + HORNER_STEPS * HORNER_LAT + 2;
  localparam int unsigned KIN_LAT      = 5;
  localparam int unsigned CORE_LAT     = SIN_LAT + KIN_LAT;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_HEIGHT  = 2'd0,
    CFG_UPPER_ARM    = 2'd1,
    CFG_ELBOW_OFFSET = 2'd2,
    CFG_FOREARM      = 2'd3
  } cfg_idx_t;

  // divisor d*(d+1) of Horner step i, d running 14, 12, ..., 2
  function automatic int unsigned horner_div(input int unsigned step);
    int unsigned d;
    d = 14 - 2 * step;
    return d * (d + 1);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/arm_forward_kinematics_position_core.sv -----
// ----------------------------------------------------------------------------
// arm_forward_kinematics_position_core
// Tool position of an articulated arm from three joint angles.
//
// Input channel (in_valid/in_ready): base, shoulder and elbow angles as
// binary angles, half a turn equal to 2^(ANGLE_BITS-1). Output channel
// (out_valid/out_ready): pos_x, pos_y, pos_z in whole length units.
// Link lengths come from the write port (cfg_we, cfg_addr, cfg_wdata):
// 0 base height, 1 upper arm, 2 elbow offset, 3 forearm. Write them only
// while the pipeline is empty.
// Six parallel sine pipelines (seven Horner steps of three stages each) feed
// the link products, sums, reach rounding and base rotation. Throughput is
// one item per cycle while no result waits on a low out_ready. When
// out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost.
// Reset clears all valid bits and sets the link lengths to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_forward_kinematics_position_core #(
  parameter int unsigned ANGLE_BITS     = fkp_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = fkp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [ANGLE_BITS-1:0]    in_base_angle,
  input  logic signed [ANGLE_BITS-1:0]    in_shoulder_angle,
  input  logic signed [ANGLE_BITS-1:0]    in_elbow_angle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [fkp_pkg::POS_W-1:0] out_pos_x,
  output logic signed [fkp_pkg::POS_W-1:0] out_pos_y,
  output logic signed [fkp_pkg::POS_W-1:0] out_pos_z,
  input  logic                            cfg_we,
  input  logic [fkp_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [fkp_pkg::LEN_W-1:0]       cfg_wdata
);

  localparam int unsigned AB  = ANGLE_BITS;
  localparam int unsigned TW  = TRIG_FRAC_BITS + 2;
  localparam int unsigned LAT = fkp_pkg::CORE_LAT;
  localparam logic [AB-1:0] QUARTER = {2'b01, {(AB-2){1'b0}}};

  logic en;
  logic [LAT-1:0] vld_r, vld_nxt;
  logic [fkp_pkg::LEN_W-1:0] base_height_r, upper_arm_r, elbow_offset_r, forearm_r;
  logic [AB-1:0] q1, q2, q23;
  logic [AB-1:0] ang [0:5];
  logic signed [TW-1:0] trig [0:5];
  logic [fkp_pkg::POS_W-1:0] px, py, pz;

  // advance everything unless a result waits on the receiver
  assign en       = out_ready | ~vld_r[LAT-1];
  assign in_ready = en;
  assign out_valid = vld_r[LAT-1];

  assign vld_nxt = {vld_r[LAT-2:0], in_valid & en};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_height_r  <= '0;
      upper_arm_r    <= '0;
      elbow_offset_r <= '0;
      forearm_r      <= '0;
    end else if (cfg_we) begin
      unique case (fkp_pkg::cfg_idx_t'(cfg_addr))
        fkp_pkg::CFG_BASE_HEIGHT:  base_height_r  <= cfg_wdata;
        fkp_pkg::CFG_UPPER_ARM:    upper_arm_r    <= cfg_wdata;
        fkp_pkg::CFG_ELBOW_OFFSET: elbow_offset_r <= cfg_wdata;
        fkp_pkg::CFG_FOREARM:      forearm_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    q1  = in_base_angle;
    q2  = in_shoulder_angle;
    q23 = q2 + in_elbow_angle;
    // cosine is the sine a quarter turn ahead
    ang[0] = q1 + QUARTER;
    ang[1] = q1;
    ang[2] = q2 + QUARTER;
    ang[3] = q2;
    ang[4] = q23 + QUARTER;
    ang[5] = q23;
  end

  for (genvar i = 0; i < 6; i++) begin : g_trig
    fkp_sin #(
      .ANGLE_BITS     (ANGLE_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_sin (
      .clk     (clk),
      .en      (en),
      .angle_i (ang[i]),
      .sin_o   (trig[i])
    );
  end

  fkp_kin #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_kin (
    .clk              (clk),
    .en               (en),
    .base_height      (base_height_r),
    .upper_arm_length (upper_arm_r),
    .elbow_offset     (elbow_offset_r),
    .forearm_length   (forearm_r),
    .c1_i             (trig[0]),
    .s1_i             (trig[1]),
    .c2_i             (trig[2]),
    .s2_i             (trig[3]),
    .c23_i            (trig[4]),
    .s23_i            (trig[5]),
    .pos_x            (px),
    .pos_y            (py),
    .pos_z            (pz)
  );

  assign out_pos_x = px;
  assign out_pos_y = py;
  assign out_pos_z = pz;

endmodule

`default_nettype wire

// ----- hw/rtl/fkp_horner.sv -----
// ----------------------------------------------------------------------------
// fkp_horner
// One Horner step of the sine series: h' = 1 - floor(round(x2*h) / DIV),
// in three stages: product, reciprocal multiply, remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module fkp_horner #(
  parameter int unsigned DIV   = 6,
  parameter int unsigned AUX_W = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [31:0]      x2_i,
  input  logic [30:0]      h_i,
  input  logic [AUX_W-1:0] aux_i,
  output logic [31:0]      x2_o,
  output logic [30:0]      h_o,
  output logic [AUX_W-1:0] aux_o
);

  localparam logic [63:0] RECIP = (64'd1 << 32) / 64'(DIV);
  localparam logic [7:0]  DIV_C = 8'(DIV);

  logic [63:0]      prod1;
  logic [31:0]      p_nxt, p_r, p2_r;
  logic [63:0]      prod2;
  logic [29:0]      q0_nxt, q0_r;
  logic [37:0]      rem;
  logic [29:0]      q;
  logic [30:0]      h_nxt;
  logic [31:0]      x2_a_r, x2_b_r;
  logic [AUX_W-1:0] aux_a_r, aux_b_r;

  always_comb begin
    prod1 = {32'd0, x2_i} * {33'd0, h_i};
    p_nxt = 32'((prod1 + fkp_pkg::Q30_HALF) >> 30);
    prod2 = {32'd0, p_r} * RECIP;
    q0_nxt = prod2[61:32];
    // estimate is at most one low
    rem = {6'd0, p2_r} - ({8'd0, q0_r} * {30'd0, DIV_C});
    q = (rem >= {30'd0, DIV_C}) ? q0_r + 30'd1 : q0_r;
    h_nxt = fkp_pkg::Q30_ONE - {1'b0, q};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_nxt;
      x2_a_r  <= x2_i;
      aux_a_r <= aux_i;
      q0_r    <= q0_nxt;
      p2_r    <= p_r;
      x2_b_r  <= x2_a_r;
      aux_b_r <= aux_a_r;
      h_o     <= h_nxt;
      x2_o    <= x2_b_r;
      aux_o   <= aux_b_r;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fkp_sin.sv -----
// ----------------------------------------------------------------------------
// fkp_sin
// Pipelined sine of a binary angle: quarter-wave fold, Q30 radians, Taylor
// series in Horner form, rounding to the output format and sign restore.
// ----------------------------------------------------------------------------
`default_nettype none

module fkp_sin #(
  parameter int unsigned ANGLE_BITS     = fkp_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = fkp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [ANGLE_BITS-1:0]          angle_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o
);

  localparam int unsigned AB    = ANGLE_BITS;
  localparam int unsigned TF    = TRIG_FRAC_BITS;
  localparam int unsigned PW    = AB + 30;
  localparam int unsigned NS    = fkp_pkg::HORNER_STEPS;
  localparam int unsigned SH    = 30 - TF;
  localparam logic [AB-2:0] QUARTER = {1'b1, {(AB-2){1'b0}}};
  localparam logic [PW-1:0] X_RND   = {{(PW-1){1'b0}}, 1'b1} << (AB - 3);
  localparam logic [32:0]   V_RND   = 33'd1 << SH;
  localparam logic [TF:0]   LIM     = {1'b1, {TF{1'b0}}};

  logic [1:0]    quad;
  logic [AB-2:0] r;
  logic [PW-1:0] xprod;
  logic [30:0]   x_nxt, x_r;
  logic [1:0]    quad_r;
  logic [61:0]   xsq;
  logic [31:0]   x2_nxt;

  logic [31:0] x2_c [0:NS];
  logic [30:0] h_c  [0:NS];
  logic [32:0] aux_c [0:NS];

  logic [61:0] vprod;
  logic [30:0] v_nxt, v_r;
  logic [1:0]  quad_v_r;
  logic [32:0] vt;
  logic [TF:0] mag;
  logic [TF:0] mag_c;

  always_comb begin
    quad   = angle_i[AB-1:AB-2];
    r      = quad[0] ? QUARTER - {1'b0, angle_i[AB-3:0]} : {1'b0, angle_i[AB-3:0]};
    xprod  = PW'(r) * PW'(fkp_pkg::HALF_PI_Q30);
    x_nxt  = 31'((xprod + X_RND) >> (AB - 2));
    xsq    = {31'd0, x_r} * {31'd0, x_r};
    x2_nxt = 32'(({2'd0, xsq} + fkp_pkg::Q30_HALF) >> 30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      quad_r <= quad;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_c[0]  <= x2_nxt;
      aux_c[0] <= {quad_r, x_r};
    end
  end

  assign h_c[0] = fkp_pkg::Q30_ONE;

  for (genvar i = 0; i < NS; i++) begin : g_step
    fkp_horner #(
      .DIV   (fkp_pkg::horner_div(i)),
      .AUX_W (33)
    ) u_step (
      .clk   (clk),
      .en    (en),
      .x2_i  (x2_c[i]),
      .h_i   (h_c[i]),
      .aux_i (aux_c[i]),
      .x2_o  (x2_c[i+1]),
      .h_o   (h_c[i+1]),
      .aux_o (aux_c[i+1])
    );
  end

  always_comb begin
    vprod = {31'd0, aux_c[NS][30:0]} * {31'd0, h_c[NS]};
    v_nxt = 31'(({2'd0, vprod} + fkp_pkg::Q30_HALF) >> 30);
    vt    = ({1'b0, v_r, 1'b0} + V_RND) >> (SH + 1);
    mag   = vt[TF:0];
    // clamp a sine that rounds above one
    mag_c = (mag > LIM) ? LIM : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r      <= v_nxt;
      quad_v_r <= aux_c[NS][32:31];
      sin_o    <= quad_v_r[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fkp_kin.sv -----
// ----------------------------------------------------------------------------
// fkp_kin
// Position back end: link products, reach and height sums, reach rounding,
// base rotation products and final rounding to whole length units.
// ----------------------------------------------------------------------------
`default_nettype none

module fkp_kin #(
  parameter int unsigned TRIG_FRAC_BITS = fkp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [fkp_pkg::LEN_W-1:0]         base_height,
  input  logic [fkp_pkg::LEN_W-1:0]         upper_arm_length,
  input  logic [fkp_pkg::LEN_W-1:0]         elbow_offset,
  input  logic [fkp_pkg::LEN_W-1:0]         forearm_length,
  input  logic signed [TRIG_FRAC_BITS+1:0]  c1_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  s1_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  c2_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  s2_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  c23_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  s23_i,
  output logic [fkp_pkg::POS_W-1:0]         pos_x,
  output logic [fkp_pkg::POS_W-1:0]         pos_y,
  output logic [fkp_pkg::POS_W-1:0]         pos_z
);

  localparam int unsigned TF  = TRIG_FRAC_BITS;
  localparam int unsigned TW  = TF + 2;
  localparam int unsigned PW  = TF + 19;
  localparam int unsigned SW  = TF + 21;
  localparam int unsigned RW  = fkp_pkg::REACH_W;
  localparam int unsigned XW  = TW + RW;
  localparam int unsigned OW  = fkp_pkg::POS_W;
  localparam int unsigned XS  = TF + fkp_pkg::REACH_FRAC;
  localparam logic [SW+1:0] Z_RND = {{(SW+1){1'b0}}, 1'b1} << TF;
  localparam logic [XW+1:0] X_RND = {{(XW+1){1'b0}}, 1'b1} << XS;

  logic signed [PW-1:0] l4c23_r, l3s23_r, l2c2_r, l3c23_r, l4s23_r, l2s2_r;
  logic signed [TW-1:0] c1_a_r, s1_a_r, c1_b_r, s1_b_r, c1_c_r, s1_c_r;
  logic signed [SW-1:0] reach_f_nxt, reach_f_r, pz_f_nxt, pz_f_r;
  logic signed [RW-1:0] reach_nxt, reach_r;
  logic signed [SW+1:0] zt;
  logic [OW-1:0]        pz_nxt, pz_r, pz_d_r;
  logic signed [XW-1:0] px_f_r, py_f_r;
  logic signed [XW+1:0] xt, yt;

  always_ff @(posedge clk) begin
    if (en) begin
      l4c23_r <= $signed({1'b0, forearm_length}) * c23_i;
      l3s23_r <= $signed({1'b0, elbow_offset}) * s23_i;
      l2c2_r  <= $signed({1'b0, upper_arm_length}) * c2_i;
      l3c23_r <= $signed({1'b0, elbow_offset}) * c23_i;
      l4s23_r <= $signed({1'b0, forearm_length}) * s23_i;
      l2s2_r  <= $signed({1'b0, upper_arm_length}) * s2_i;
      c1_a_r  <= c1_i;
      s1_a_r  <= s1_i;
    end
  end

  always_comb begin
    reach_f_nxt = SW'(l4c23_r) - SW'(l3s23_r) + SW'(l2c2_r);
    pz_f_nxt    = SW'($signed({1'b0, base_height, {TF{1'b0}}})) + SW'(l3c23_r)
                  + SW'(l4s23_r) + SW'(l2s2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reach_f_r <= reach_f_nxt;
      pz_f_r    <= pz_f_nxt;
      c1_b_r    <= c1_a_r;
      s1_b_r    <= s1_a_r;
    end
  end

  if (TF >= fkp_pkg::REACH_FRAC) begin : g_reach_rnd
    localparam int unsigned RS = TF - fkp_pkg::REACH_FRAC;
    localparam logic [SW+1:0] R_RND = {{(SW+1){1'b0}}, 1'b1} << RS;
    logic signed [SW+1:0] rt;
    always_comb begin
      rt = $signed({reach_f_r[SW-1], reach_f_r, 1'b0}) + $signed(R_RND)
           - $signed({{(SW+1){1'b0}}, reach_f_r[SW-1]});
      reach_nxt = RW'(rt >>> (RS + 1));
    end
  end else begin : g_reach_shl
    always_comb begin
      reach_nxt = RW'(reach_f_r <<< (fkp_pkg::REACH_FRAC - TF));
    end
  end

  always_comb begin
    // half away from zero: drop one from the bias on negative values
    zt = $signed({pz_f_r[SW-1], pz_f_r, 1'b0}) + $signed(Z_RND)
         - $signed({{(SW+1){1'b0}}, pz_f_r[SW-1]});
    pz_nxt = OW'(zt >>> (TF + 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reach_r <= reach_nxt;
      pz_r    <= pz_nxt;
      c1_c_r  <= c1_b_r;
      s1_c_r  <= s1_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_f_r <= XW'(c1_c_r) * XW'(reach_r);
      py_f_r <= XW'(s1_c_r) * XW'(reach_r);
      pz_d_r <= pz_r;
    end
  end

  always_comb begin
    xt = $signed({px_f_r[XW-1], px_f_r, 1'b0}) + $signed(X_RND)
         - $signed({{(XW+1){1'b0}}, px_f_r[XW-1]});
    yt = $signed({py_f_r[XW-1], py_f_r, 1'b0}) + $signed(X_RND)
         - $signed({{(XW+1){1'b0}}, py_f_r[XW-1]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= OW'(xt >>> (XS + 1));
      pos_y <= OW'(yt >>> (XS + 1));
      pos_z <= pz_d_r;
    end
  end

endmodule

`default_nettype wire
